// ===== rtl/core/kpq_pkg.sv =====
package kpq_pkg;

   localparam int MAX_ENTRIES_DEF = 64;
   localparam int KEY_W           = 32;
   localparam int PAYLOAD_W       = 32;
   localparam int RANGE_W         = 6;
   localparam int CSR_INDEX_W     = 1;

   typedef enum logic [CSR_INDEX_W-1:0] {
      CSR_RANGE_LOW  = 1'b0,
      CSR_RANGE_HIGH = 1'b1
   } csr_index_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_value;
      logic [PAYLOAD_W-1:0]    payload;
      logic                    is_final;
   } req_data_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] sorted_key;
      logic [PAYLOAD_W-1:0]    sorted_payload;
      logic                    end_of_set;
   } rsp_data_type;

   typedef struct packed {
      logic signed [KEY_W-1:0] key_value;
      logic [PAYLOAD_W-1:0]    payload;
   } entry_type;

   typedef struct packed {
      logic [RANGE_W-1:0] lo;
      logic [RANGE_W-1:0] hi;
   } range_type;

   typedef enum logic [3:0] {
      S_LOAD,
      S_START,
      S_POP,
      S_POP_WAIT,
      S_PIVOT,
      S_SCAN_RD,
      S_SCAN_CMP,
      S_SCAN_WR2,
      S_FIN_CMP,
      S_FIN_WR2,
      S_PUSH2,
      S_EMIT_RD,
      S_EMIT_SHOW
   } state_type;

endpackage

// ===== rtl/core/key_payload_quicksort_unit.sv =====
// Channel   Direction  Handshake             Beat
// req_      in         req_valid/req_stall   one key/payload pair, is_final ends the set
// rsp_      out        rsp_valid/rsp_stall   one sorted pair, end_of_set on the last
// csr_      in         csr_valid/csr_ready   range_low (index 0) or range_high (index 1)
//
// Load takes one beat per cycle; the final beat starts the sort.
// Sort: each partition, with its setup and range stack handling, is paced by
// the single write port of the entry memory.
// Emit reads each beat from memory, then shows it, holding it while rsp_stall is high.
// Reset is synchronous; no clearing pass, the block loads right after reset.
// req_stall stays high from the final beat until the last result beat is taken.
module key_payload_quicksort_unit
   import kpq_pkg::*;
#(
   parameter int MAX_ENTRIES = MAX_ENTRIES_DEF
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_data_type           req_data,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_data_type           rsp_data,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [RANGE_W-1:0]     csr_wdata
);

   localparam int IW    = $clog2(MAX_ENTRIES);
   localparam int CW    = $clog2(MAX_ENTRIES + 1);
   localparam int EXT_W = RANGE_W + 1;

   entry_type entry_mem [MAX_ENTRIES];
   range_type stack_mem [MAX_ENTRIES];

   state_type state_ff, state_in;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] sp_ff, sp_in;
   logic [RANGE_W-1:0] range_low_ff, range_high_ff;
   logic [IW-1:0] j_ff, j_in, place_ff, place_in;
   logic [IW-1:0] lo_ff, lo_in, hi_ff, hi_in, k_ff, k_in;
   entry_type pivot_ff, pivot_in;
   entry_type rd_a_ff, rd_b_ff;
   range_type stack_rd_ff;

   logic mem_wr_en, rd_en_a, rd_en_b;
   logic [IW-1:0] mem_wr_addr, rd_addr_a, rd_addr_b;
   entry_type mem_wr_data;
   logic stk_wr_en, stk_rd_en;
   logic [IW-1:0] stk_wr_addr, stk_rd_addr;
   range_type stk_wr_data;

   logic req_fire, store_ok, key_less;
   logic [EXT_W-1:0] cnt_ext, hi_clamp;
   logic start_push, pop_skip, push1_ok, push2_ok, stack_room, last_beat;
   logic [IW-1:0] last_idx, pop_lo, pop_hi;
   logic [CW-1:0] cnt_m1, sp_m1;

   assign csr_ready = 1'b1;
   assign req_fire  = req_valid && !req_stall;
   assign store_ok  = count_ff < CW'(MAX_ENTRIES);
   assign key_less  = $signed(rd_a_ff.key_value) < $signed(pivot_ff.key_value);

   assign cnt_ext  = EXT_W'(count_ff);
   assign hi_clamp = (EXT_W'(range_high_ff) > cnt_ext - EXT_W'(1)) ?
                     (cnt_ext - EXT_W'(1)) : EXT_W'(range_high_ff);
   assign start_push = (count_ff != '0) && (EXT_W'(range_low_ff) < hi_clamp);

   assign pop_lo   = stack_rd_ff.lo[IW-1:0];
   assign pop_hi   = stack_rd_ff.hi[IW-1:0];
   assign pop_skip = (EXT_W'(stack_rd_ff.hi) >= cnt_ext) || (stack_rd_ff.lo >= stack_rd_ff.hi);

   assign stack_room = sp_ff < CW'(MAX_ENTRIES);
   assign push1_ok = ({1'b0, place_ff} + (IW+1)'(1) < {1'b0, hi_ff}) && stack_room;
   assign push2_ok = (place_ff != '0) && ({1'b0, lo_ff} + (IW+1)'(1) < {1'b0, place_ff})
                     && stack_room;

   assign cnt_m1    = count_ff - CW'(1);
   assign sp_m1     = sp_ff - CW'(1);
   assign last_idx  = cnt_m1[IW-1:0];
   assign last_beat = (k_ff == last_idx);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire && req_data.is_final) state_in = S_START;
         end
         S_START: begin
            if (count_ff == '0)  state_in = S_LOAD;
            else if (start_push) state_in = S_POP;
            else                 state_in = S_EMIT_RD;
         end
         S_POP:      state_in = (sp_ff == '0) ? S_EMIT_RD : S_POP_WAIT;
         S_POP_WAIT: state_in = pop_skip ? S_POP : S_PIVOT;
         S_PIVOT:    state_in = S_SCAN_RD;
         S_SCAN_RD:  state_in = (j_ff == hi_ff) ? S_FIN_CMP : S_SCAN_CMP;
         S_SCAN_CMP: state_in = key_less ? S_SCAN_WR2 : S_SCAN_RD;
         S_SCAN_WR2: state_in = S_SCAN_RD;
         S_FIN_CMP:  state_in = S_FIN_WR2;
         S_FIN_WR2:  state_in = S_PUSH2;
         S_PUSH2:    state_in = S_POP;
         S_EMIT_RD:  state_in = S_EMIT_SHOW;
         S_EMIT_SHOW: begin
            if (!rsp_stall) state_in = last_beat ? S_LOAD : S_EMIT_RD;
         end
         default: state_in = S_LOAD;
      endcase
   end

   // memory ports and handshakes
   always_comb begin
      req_stall   = 1'b1;
      rsp_valid   = 1'b0;
      mem_wr_en   = 1'b0;
      mem_wr_addr = place_ff;
      mem_wr_data = rd_a_ff;
      rd_en_a     = 1'b0;
      rd_en_b     = 1'b0;
      rd_addr_a   = j_ff;
      rd_addr_b   = place_ff;
      stk_wr_en   = 1'b0;
      stk_wr_addr = sp_ff[IW-1:0];
      stk_wr_data = '{lo: RANGE_W'(place_ff + IW'(1)), hi: RANGE_W'(hi_ff)};
      stk_rd_en   = 1'b0;
      stk_rd_addr = cnt_m1[IW-1:0];
      case (state_ff)
         S_LOAD: begin
            req_stall   = 1'b0;
            mem_wr_en   = req_fire && store_ok;
            mem_wr_addr = count_ff[IW-1:0];
            mem_wr_data = '{key_value: req_data.key_value, payload: req_data.payload};
         end
         S_START: begin
            stk_wr_en   = start_push;
            stk_wr_addr = '0;
            stk_wr_data = '{lo: range_low_ff, hi: hi_clamp[RANGE_W-1:0]};
         end
         S_POP: begin
            stk_rd_en   = (sp_ff != '0);
            stk_rd_addr = sp_m1[IW-1:0];
         end
         S_POP_WAIT: begin
            rd_en_a   = !pop_skip;
            rd_addr_a = pop_hi;
         end
         S_SCAN_RD: begin
            if (j_ff == hi_ff) begin
               rd_en_a   = 1'b1;
               rd_addr_a = place_ff;
            end else begin
               rd_en_a = 1'b1;
               rd_en_b = 1'b1;
            end
         end
         S_SCAN_CMP: begin
            mem_wr_en = key_less;
         end
         S_SCAN_WR2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = j_ff;
            mem_wr_data = rd_b_ff;
         end
         S_FIN_CMP: begin
            mem_wr_en   = 1'b1;
            mem_wr_data = pivot_ff;
         end
         S_FIN_WR2: begin
            mem_wr_en   = 1'b1;
            mem_wr_addr = hi_ff;
            stk_wr_en   = push1_ok;
         end
         S_PUSH2: begin
            stk_wr_en   = push2_ok;
            stk_wr_data = '{lo: RANGE_W'(lo_ff), hi: RANGE_W'(place_ff - IW'(1))};
         end
         S_EMIT_RD: begin
            rd_en_a   = 1'b1;
            rd_addr_a = k_ff;
         end
         S_EMIT_SHOW: begin
            rsp_valid = 1'b1;
         end
         default: ;
      endcase
   end

   assign rsp_data = '{sorted_key: rd_a_ff.key_value, sorted_payload: rd_a_ff.payload,
                       end_of_set: last_beat};

   // datapath next values
   always_comb begin
      count_in = count_ff;
      sp_in    = sp_ff;
      j_in     = j_ff;
      place_in = place_ff;
      lo_in    = lo_ff;
      hi_in    = hi_ff;
      k_in     = k_ff;
      pivot_in = pivot_ff;
      case (state_ff)
         S_LOAD: begin
            if (req_fire && store_ok) count_in = count_ff + CW'(1);
         end
         S_START: begin
            k_in  = '0;
            sp_in = start_push ? CW'(1) : '0;
         end
         S_POP: begin
            if (sp_ff != '0) sp_in = sp_ff - CW'(1);
         end
         S_POP_WAIT: begin
            lo_in    = pop_lo;
            hi_in    = pop_hi;
            j_in     = pop_lo;
            place_in = pop_lo;
         end
         S_PIVOT: pivot_in = rd_a_ff;
         S_SCAN_CMP: begin
            if (key_less) place_in = place_ff + IW'(1);
            else          j_in     = j_ff + IW'(1);
         end
         S_SCAN_WR2: j_in = j_ff + IW'(1);
         S_FIN_WR2: begin
            if (push1_ok) sp_in = sp_ff + CW'(1);
         end
         S_PUSH2: begin
            if (push2_ok) sp_in = sp_ff + CW'(1);
         end
         S_EMIT_SHOW: begin
            if (!rsp_stall) begin
               if (last_beat) count_in = '0;
               else           k_in     = k_ff + IW'(1);
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_LOAD;
         count_ff      <= '0;
         sp_ff         <= '0;
         range_low_ff  <= '0;
         range_high_ff <= RANGE_W'(63);
      end else begin
         state_ff <= state_in;
         count_ff <= count_in;
         sp_ff    <= sp_in;
         if (csr_valid && csr_ready) begin
            case (csr_index_type'(csr_index))
               CSR_RANGE_LOW:  range_low_ff  <= csr_wdata;
               CSR_RANGE_HIGH: range_high_ff <= csr_wdata;
               default: ;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      j_ff     <= j_in;
      place_ff <= place_in;
      lo_ff    <= lo_in;
      hi_ff    <= hi_in;
      k_ff     <= k_in;
      pivot_ff <= pivot_in;
   end

   // entry memory: one write port, two registered read ports
   always_ff @(posedge clock) begin
      if (mem_wr_en) entry_mem[mem_wr_addr] <= mem_wr_data;
      if (rd_en_a)   rd_a_ff <= entry_mem[rd_addr_a];
      if (rd_en_b)   rd_b_ff <= entry_mem[rd_addr_b];
   end

   // range stack memory
   always_ff @(posedge clock) begin
      if (stk_wr_en) stack_mem[stk_wr_addr] <= stk_wr_data;
      if (stk_rd_en) stack_rd_ff <= stack_mem[stk_rd_addr];
   end

endmodule

// ===== rtl/core/kpq_checker.sv =====
module kpq_checker
   import kpq_pkg::*;
(
   input logic         clock,
   input logic         reset,
   input logic         req_stall,
   input logic         rsp_valid,
   input logic         rsp_stall,
   input rsp_data_type rsp_data
);

   // hold a stalled result beat
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled result beat changed");

   // no loading while results go out
   a_no_load_during_emit: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall)
      else $error("input taken while emitting");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result beat right after reset");

   // each beat needs a fresh memory read
   a_beat_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall |=> !rsp_valid)
      else $error("result beats back to back");

   a_reload_after_last: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && rsp_data.end_of_set |=> !req_stall)
      else $error("not loading after last beat");

endmodule

bind key_payload_quicksort_unit kpq_checker u_kpq_checker (
   .clock     (clock),
   .reset     (reset),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

// ===== bench/tb_key_payload_quicksort_unit.sv =====
`timescale 1ns / 100ps

module tb_key_payload_quicksort_unit;
   import kpq_pkg::*;

   localparam int CYCLE_LIMIT  = 1_000_000;
   localparam int DRAIN_CYCLES = 24;
   localparam int HOLD_CYCLES  = 400;

   logic                   clock     = 1'b0;
   logic                   reset     = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   req_data_type           req_data  = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   rsp_data_type           rsp_data;
   logic                   csr_valid = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [RANGE_W-1:0]     csr_wdata = '0;

   key_payload_quicksort_unit dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   always #5 clock = ~clock;

   // sorter shadow state
   logic signed [KEY_W-1:0] key_copy [MAX_ENTRIES_DEF];
   logic [PAYLOAD_W-1:0]    payload_copy [MAX_ENTRIES_DEF];
   int                      loaded_count = 0;
   int                      win_first    = 0;
   int                      win_last     = 63;
   rsp_data_type            sorted_beats_due [$];

   int mismatch_count = 0;
   int cycle_count    = 0;
   int pairs_sent     = 0;

   // sender and receiver pacing
   bit   sender_gaps = 1'b0;
   int   burst_left  = 0;
   logic rx_jitter   = 1'b0;
   int   hold_asked  = 0;

   function automatic void swap_entries(int a, int b);
      logic signed [KEY_W-1:0] k;
      logic [PAYLOAD_W-1:0]    p;
      k = key_copy[a];
      key_copy[a] = key_copy[b];
      key_copy[b] = k;
      p = payload_copy[a];
      payload_copy[a] = payload_copy[b];
      payload_copy[b] = p;
   endfunction

   // pivot is the last entry; strictly smaller keys move left
   function automatic int split_window(int lo, int hi);
      logic signed [KEY_W-1:0] pivot;
      int place;
      pivot = key_copy[hi];
      place = lo;
      for (int j = lo; j < hi; j++) begin
         if (key_copy[j] < pivot) begin
            swap_entries(place, j);
            place++;
         end
      end
      swap_entries(place, hi);
      return place;
   endfunction

   function automatic void sort_window();
      range_type spans [$];
      range_type r;
      int lo, hi, p;
      lo = win_first;
      hi = (win_last > loaded_count - 1) ? loaded_count - 1 : win_last;
      if (lo < hi) begin
         r.lo = RANGE_W'(lo);
         r.hi = RANGE_W'(hi);
         spans.push_back(r);
      end
      while (spans.size() > 0) begin
         r = spans.pop_back();
         lo = r.lo;
         hi = r.hi;
         if (hi >= loaded_count || lo >= hi) continue;
         p = split_window(lo, hi);
         if (p + 1 < hi) begin
            r.lo = RANGE_W'(p + 1);
            r.hi = RANGE_W'(hi);
            spans.push_back(r);
         end
         if (p > 0 && lo < p - 1) begin
            r.lo = RANGE_W'(lo);
            r.hi = RANGE_W'(p - 1);
            spans.push_back(r);
         end
      end
   endfunction

   function automatic void absorb_pair(req_data_type item);
      rsp_data_type beat;
      if (loaded_count < MAX_ENTRIES_DEF) begin
         key_copy[loaded_count]     = item.key_value;
         payload_copy[loaded_count] = item.payload;
         loaded_count++;
      end
      if (!item.is_final) return;
      sort_window();
      for (int k = 0; k < loaded_count; k++) begin
         beat.sorted_key     = key_copy[k];
         beat.sorted_payload = payload_copy[k];
         beat.end_of_set     = (k == loaded_count - 1);
         sorted_beats_due.push_back(beat);
      end
      loaded_count = 0;
   endfunction

   function automatic logic signed [KEY_W-1:0] pick_key();
      case ($urandom_range(0, 9))
         0, 1, 2: pick_key = KEY_W'((int'($urandom_range(0, 6)) - 3) * 65536);
         3:       pick_key = $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
         default: pick_key = $urandom();
      endcase
   endfunction

   task automatic send_pair(input logic signed [KEY_W-1:0] key,
                            input logic [PAYLOAD_W-1:0] payload, input logic last);
      req_data_type item;
      item.key_value = key;
      item.payload   = payload;
      item.is_final  = last;
      req_valid <= 1'b1;
      req_data  <= item;
      do @(posedge clock); while (req_stall);
      absorb_pair(item);
      pairs_sent++;
      if (sender_gaps) begin
         if (burst_left == 0) begin
            req_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
            burst_left = $urandom_range(1, 12);
         end else begin
            burst_left--;
         end
      end
   endtask

   task automatic send_set(input int count);
      for (int i = 0; i < count; i++) send_pair(pick_key(), $urandom(), i == count - 1);
   endtask

   // hold valid across both beats, then drop it
   task automatic write_ranges(input int first, input int last);
      csr_valid <= 1'b1;
      csr_index <= CSR_RANGE_LOW;
      csr_wdata <= RANGE_W'(first);
      do @(posedge clock); while (!csr_ready);
      win_first = first;
      csr_index <= CSR_RANGE_HIGH;
      csr_wdata <= RANGE_W'(last);
      do @(posedge clock); while (!csr_ready);
      win_last = last;
      csr_valid <= 1'b0;
   endtask

   task automatic wait_drained();
      req_valid <= 1'b0;
      while (sorted_beats_due.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_extreme_keys();
      sender_gaps = 1'b0;
      rx_jitter  <= 1'b0;
      send_pair(32'h7FFF_FFFF, 32'hFFFF_FFFF, 1'b0);
      send_pair(32'h8000_0000, 32'h0000_0000, 1'b0);
      send_pair(32'h0000_0000, 32'h0000_0001, 1'b0);
      send_pair(32'hFFFF_FFFF, 32'h0000_0002, 1'b0);
      send_pair(32'h0001_0000, 32'h0000_0003, 1'b0);
      send_pair(32'h0001_0000, 32'h0000_0004, 1'b0);
      send_pair(32'h8000_0000, 32'h0000_0005, 1'b0);
      send_pair(32'h7FFF_FFFF, 32'h0000_0006, 1'b0);
      send_pair(32'hFFFF_0000, 32'h0000_0007, 1'b0);
      send_pair(32'h0001_0000, 32'hA5A5_5A5A, 1'b1);
      wait_drained();
   endtask

   task automatic test_single_entry();
      send_pair(32'h1234_5678, 32'h8765_4321, 1'b1);
      wait_drained();
   endtask

   task automatic test_sort_ranges();
      sender_gaps = 1'b1;
      rx_jitter  <= 1'b1;
      write_ranges(2, 5);
      send_set(8);
      wait_drained();
      write_ranges(5, 2);
      send_set(4);
      wait_drained();
      write_ranges(63, 63);
      send_set(3);
      wait_drained();
      write_ranges(0, 0);
      send_set(3);
      wait_drained();
   endtask

   // the pair on the final beat is dropped once 64 are stored
   task automatic test_full_store();
      write_ranges(0, 63);
      send_set(MAX_ENTRIES_DEF + 2);
      wait_drained();
   endtask

   task automatic test_output_backpressure();
      sender_gaps = 1'b0;
      rx_jitter  <= 1'b0;
      hold_asked <= hold_asked + 1;
      send_set(8);
      send_set(6);
      wait_drained();
   endtask

   task automatic test_random_sets();
      int count;
      int stop_at;
      stop_at = pairs_sent + 15;
      while (pairs_sent < stop_at) begin
         if ($urandom_range(0, 2) == 0) begin
            wait_drained();
            case ($urandom_range(0, 4))
               0:       write_ranges(0, 63);
               1:       write_ranges(63, 0);
               2:       write_ranges(0, $urandom_range(0, 63));
               default: write_ranges($urandom_range(0, 10), $urandom_range(0, 63));
            endcase
         end
         sender_gaps = ($urandom_range(0, 3) != 0);
         rx_jitter  <= ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 19))
            0:             count = MAX_ENTRIES_DEF;
            1, 2, 3:       count = $urandom_range(13, 40);
            default:       count = $urandom_range(1, 12);
         endcase
         send_set(count);
      end
      wait_drained();
   endtask

   // receiver: long hold on request, otherwise no stall or, with rx_jitter, alternating run and stall phases
   always @(posedge clock) begin : receiver
      static int hold_served   = 0;
      static int hold_left     = 0;
      static int rx_phase_left = 0;
      static bit rx_stalled    = 1'b0;
      if (hold_served != hold_asked) begin
         hold_served = hold_asked;
         hold_left   = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_stall <= 1'b1;
      end else if (!rx_jitter) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rx_phase_left == 0) begin
            rx_stalled    = !rx_stalled;
            rx_phase_left = rx_stalled ? $urandom_range(1, 5) : $urandom_range(1, 10);
         end else begin
            rx_phase_left--;
         end
         rsp_stall <= rx_stalled;
      end
   end

   always @(posedge clock) begin : check_beat
      rsp_data_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (sorted_beats_due.size() == 0) begin
            $display("%0t: result beat with nothing expected: key %h payload %h last %b",
                     $time, rsp_data.sorted_key, rsp_data.sorted_payload,
                     rsp_data.end_of_set);
            mismatch_count++;
         end else begin
            want = sorted_beats_due.pop_front();
            if (rsp_data.sorted_key !== want.sorted_key) begin
               $display("%0t: sorted_key expected %h actual %h",
                        $time, want.sorted_key, rsp_data.sorted_key);
               mismatch_count++;
            end
            if (rsp_data.sorted_payload !== want.sorted_payload) begin
               $display("%0t: sorted_payload expected %h actual %h",
                        $time, want.sorted_payload, rsp_data.sorted_payload);
               mismatch_count++;
            end
            if (rsp_data.end_of_set !== want.end_of_set) begin
               $display("%0t: end_of_set expected %b actual %b",
                        $time, want.end_of_set, rsp_data.end_of_set);
               mismatch_count++;
            end
         end
      end
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("%0t: timeout with %0d beats outstanding", $time, sorted_beats_due.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      test_extreme_keys();
      test_single_entry();
      test_sort_ranges();
      test_full_store();
      test_output_backpressure();
      test_random_sets();
      wait_drained();
      if (mismatch_count == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule

// ===== files.f =====
rtl/core/kpq_pkg.sv
rtl/core/key_payload_quicksort_unit.sv
rtl/core/kpq_checker.sv
bench/tb_key_payload_quicksort_unit.sv
